@@ src/rtsv_pkg.sv @@
// shared types, constants and helper functions for the rtc set-time validator
package rtsv_pkg;

  localparam logic [11:0] YearBase   = 12'd1900;
  localparam logic [11:0] MinYear    = 12'd1970;
  localparam logic [11:0] CentA      = 12'd1900;
  localparam logic [11:0] CentB      = 12'd2100;
  localparam logic [11:0] MaxOffset  = 12'd169;
  localparam logic [11:0] YearWrap   = 12'd100;
  localparam logic [11:0] EpochReset = 12'd1900;
  localparam logic [5:0]  HourLimit  = 6'd24;
  localparam logic [5:0]  MinSecLim  = 6'd60;
  localparam logic [3:0]  MonthCount = 4'd12;
  localparam logic [3:0]  FebIndex   = 4'd1;

  typedef struct packed {
    logic [7:0] year_since_1900;
    logic [3:0] month_index;
    logic [2:0] weekday;
    logic [5:0] day_of_month;
    logic [5:0] hour_in;
    logic [5:0] minute_in;
    logic [5:0] second_in;
  } in_item_t;

  typedef struct packed {
    logic       status;
    logic [6:0] second_bcd;
    logic [6:0] minute_bcd;
    logic [5:0] hour_bcd;
    logic [5:0] date_bcd;
    logic [4:0] month_bcd;
    logic [2:0] weekday_out;
    logic [7:0] year_bcd;
  } res_item_t;

  // two bcd digits for 0..99, quotient by reciprocal multiply
  function automatic logic [7:0] to_bcd(input logic [6:0] v);
    logic [13:0] p;
    logic [3:0]  q;
    logic [6:0]  r;
    p = {7'b0, v} * 14'd103;
    q = p[13:10];
    r = v - {q, 3'b0} - {2'b0, q, 1'b0};
    return {q, r[3:0]};
  endfunction

  // days in month for a zero-based month index, february without leap day
  function automatic logic [4:0] month_len(input logic [3:0] idx);
    logic [4:0] d;
    unique case (idx)
      4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: d = 5'd31;
      4'd3, 4'd5, 4'd8, 4'd10:                  d = 5'd30;
      4'd1:                                     d = 5'd28;
      default:                                  d = 5'd0;
    endcase
    return d;
  endfunction

endpackage

@@ src/rtsv_check.sv @@
// range checks and bcd packing for one calendar time
module rtsv_check
  import rtsv_pkg::*;
(
  input  in_item_t   item,
  input  logic [11:0] epoch_year,
  output res_item_t  res
);

  logic [11:0] full_year;
  logic [12:0] diff;
  logic [11:0] offset;
  logic [11:0] offset_wrap;
  logic        leap;
  logic [5:0]  limit;
  logic        year_ok;
  logic        month_ok;
  logic        date_ok;
  logic        clock_ok;
  logic        offset_ok;
  logic        ok;

  always_comb begin
    full_year = {4'b0, item.year_since_1900} + YearBase;
    diff      = {1'b0, full_year} - {1'b0, epoch_year};
    offset    = diff[11:0];
    // century years inside the input range: only 2000 is a leap year
    leap      = (full_year[1:0] == 2'b00) && (full_year != CentA) && (full_year != CentB);
    limit     = {1'b0, month_len(item.month_index)} +
                {5'b0, (item.month_index == FebIndex) && leap};
    year_ok   = full_year >= MinYear;
    month_ok  = item.month_index < MonthCount;
    date_ok   = (item.day_of_month != 6'd0) && (item.day_of_month <= limit);
    clock_ok  = (item.hour_in < HourLimit) && (item.minute_in < MinSecLim) &&
                (item.second_in < MinSecLim);
    offset_ok = !diff[12] && (offset <= MaxOffset);
    ok        = year_ok && month_ok && date_ok && clock_ok && offset_ok;
    offset_wrap = (offset >= YearWrap) ? offset - YearWrap : offset;

    res = '0;
    res.status = !ok;
    if (ok) begin
      res.second_bcd  = 7'(to_bcd({1'b0, item.second_in}));
      res.minute_bcd  = 7'(to_bcd({1'b0, item.minute_in}));
      res.hour_bcd    = 6'(to_bcd({1'b0, item.hour_in}));
      res.date_bcd    = 6'(to_bcd({1'b0, item.day_of_month}));
      res.month_bcd   = 5'(to_bcd({3'b0, item.month_index} + 7'd1));
      res.weekday_out = item.weekday;
      res.year_bcd    = to_bcd(offset_wrap[6:0]);
    end
  end

endmodule

@@ src/rtc_set_time_validate_bcd.sv @@
// top level: input register, check and pack logic, result register
// throughput: one time record per cycle while out_stall is low, set by the single check-and-pack stage
// the input register keeps taking records while a result waits on out_stall,
// until both registers are full
// reset: synchronous active-low rst_n empties both stages, epoch_year returns to 1900
module rtc_set_time_validate_bcd
  import rtsv_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [11:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_year_since_1900,
  input  logic [3:0]  in_month_index,
  input  logic [2:0]  in_weekday,
  input  logic [5:0]  in_day_of_month,
  input  logic [5:0]  in_hour_in,
  input  logic [5:0]  in_minute_in,
  input  logic [5:0]  in_second_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_status,
  output logic [6:0]  out_second_bcd,
  output logic [6:0]  out_minute_bcd,
  output logic [5:0]  out_hour_bcd,
  output logic [5:0]  out_date_bcd,
  output logic [4:0]  out_month_bcd,
  output logic [2:0]  out_weekday_out,
  output logic [7:0]  out_year_bcd
);

  logic [11:0] epoch_r;
  in_item_t    s1_item_r;
  logic        s1_valid_r, s1_valid_nxt;
  res_item_t   res_r;
  res_item_t   res_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        adv_out;
  logic        in_xfer;

  rtsv_check u_check (
    .item       (s1_item_r),
    .epoch_year (epoch_r),
    .res        (res_nxt)
  );

  assign adv_out  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !adv_out;
  assign in_xfer  = in_valid && !in_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (adv_out) begin
      out_valid_nxt = s1_valid_r;
    end
    // input stage stays full while its item cannot move on
    s1_valid_nxt = in_xfer || (s1_valid_r && !adv_out);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      epoch_r     <= EpochReset;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        epoch_r <= cfg_wdata;
      end
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_item_r <= '{year_since_1900: in_year_since_1900, month_index: in_month_index,
                     weekday: in_weekday, day_of_month: in_day_of_month,
                     hour_in: in_hour_in, minute_in: in_minute_in,
                     second_in: in_second_in};
    end
    if (adv_out && s1_valid_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = res_r.status;
  assign out_second_bcd  = res_r.second_bcd;
  assign out_minute_bcd  = res_r.minute_bcd;
  assign out_hour_bcd    = res_r.hour_bcd;
  assign out_date_bcd    = res_r.date_bcd;
  assign out_month_bcd   = res_r.month_bcd;
  assign out_weekday_out = res_r.weekday_out;
  assign out_year_bcd    = res_r.year_bcd;

  // a rejected time carries all-zero bytes
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_second_bcd == 7'd0 && out_minute_bcd == 7'd0 &&
      out_hour_bcd == 6'd0 && out_date_bcd == 6'd0 && out_month_bcd == 5'd0 &&
      out_weekday_out == 3'd0 && out_year_bcd == 8'd0)
    else $error("rejected time with nonzero bytes");

  // accepted time has legal bcd digits
  a_bcd_digits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_status |-> out_second_bcd[3:0] <= 4'd9 &&
      out_minute_bcd[3:0] <= 4'd9 && out_hour_bcd[3:0] <= 4'd9 &&
      out_date_bcd[3:0] <= 4'd9 && out_year_bcd[3:0] <= 4'd9 &&
      out_year_bcd[7:4] <= 4'd9 && out_month_bcd != 5'd0)
    else $error("illegal bcd digit in accepted time");

  // input side stalls only when both stages are full and the result is held
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid && out_stall)
    else $error("input stalled with room in the pipeline");

  // a held result with a full input stage keeps the input stage
  a_hold_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> s1_valid_r && out_valid)
    else $error("pipeline lost an item while stalled");

endmodule
